// ----- rtl/core/upa_pkg.sv -----
// Shared constants and types for the uncertainty propagation accumulator.
// Used by the channel interfaces, the serial arithmetic units and the top level.
package upa_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int SQ_BITS   = 64;
  localparam int ROOT_BITS = SQ_BITS / 2;
  localparam int MUL_BITS  = (WORD_BITS > ROOT_BITS) ? WORD_BITS : ROOT_BITS;
  localparam int PROD_BITS = 2 * MUL_BITS;
  localparam int QUOT_BITS = WORD_BITS + FRAC_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        mag_t;
  typedef logic [WORD_BITS-2:0]        err_t;
  typedef logic [MUL_BITS-1:0]         mul_t;
  typedef logic [PROD_BITS-1:0]        prod_t;
  typedef logic [PROD_BITS:0]          wide_t;
  typedef logic [SQ_BITS-1:0]          sq_t;
  typedef logic [ROOT_BITS-1:0]        root_t;
  typedef logic [QUOT_BITS-1:0]        quot_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef enum logic {
    MODE_SUM  = 1'b0,
    MODE_PROD = 1'b1
  } mode_t;

  localparam mag_t  POS_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam mag_t  NEG_MAX = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t FIX_ONE = word_t'(1) << FRAC_BITS;
  localparam wide_t HALF_LSB = wide_t'(1) << (FRAC_BITS - 1);

endpackage

// ----- rtl/core/upa_if.sv -----
// Valid/ready channel interfaces: input pairs, results, and the mode write port.
// Depends on upa_pkg for payload types.
interface upa_in_if;
  logic               valid;
  logic               ready;
  upa_pkg::word_t     value;
  upa_pkg::word_t     error;
  logic               last;
  modport source (output valid, value, error, last, input ready);
  modport sink (input valid, value, error, last, output ready);
endinterface

interface upa_out_if;
  logic               valid;
  logic               ready;
  upa_pkg::word_t     result_value;
  upa_pkg::err_t      result_error;
  upa_pkg::status_t   status;
  modport source (output valid, result_value, result_error, status, input ready);
  modport sink (input valid, result_value, result_error, status, output ready);
endinterface

interface upa_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/core/upa_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on upa_pkg.
module upa_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  upa_pkg::mul_t  a,
  input  upa_pkg::mul_t  b,
  output logic           done,
  output upa_pkg::prod_t product
);

  localparam int CW = $clog2(upa_pkg::MUL_BITS + 1);

  logic [CW-1:0]                count;
  logic                         busy;
  upa_pkg::mul_t                mcand;
  upa_pkg::prod_t               acc;
  logic [upa_pkg::MUL_BITS:0]   upper;

  assign upper = {1'b0, acc[upa_pkg::PROD_BITS-1:upa_pkg::MUL_BITS]}
               + (acc[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(upa_pkg::MUL_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      acc   <= upa_pkg::prod_t'(b);
    end else if (busy) begin
      acc <= {upper, acc[upa_pkg::MUL_BITS-1:1]};
    end
  end

  assign product = acc;

endmodule

// ----- rtl/core/upa_div.sv -----
// Restoring divider, one quotient bit per cycle: floor(num * 2^FRAC_BITS / den).
// Depends on upa_pkg.
module upa_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  upa_pkg::mag_t  num,
  input  upa_pkg::mag_t  den,
  output logic           done,
  output upa_pkg::quot_t quot
);

  localparam int CW = $clog2(upa_pkg::QUOT_BITS + 1);

  logic [CW-1:0]               count;
  logic                        busy;
  upa_pkg::mag_t               rem;
  upa_pkg::mag_t               dsr;
  upa_pkg::quot_t              dq;
  logic [upa_pkg::WORD_BITS:0] sh;
  logic [upa_pkg::WORD_BITS:0] diff;
  logic                        ge;

  assign sh   = {rem, dq[upa_pkg::QUOT_BITS-1]};
  assign ge   = sh >= {1'b0, dsr};
  assign diff = sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(upa_pkg::QUOT_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= den;
      dq  <= {num, {upa_pkg::FRAC_BITS{1'b0}}};
    end else if (busy) begin
      rem <= ge ? diff[upa_pkg::WORD_BITS-1:0] : sh[upa_pkg::WORD_BITS-1:0];
      dq  <= {dq[upa_pkg::QUOT_BITS-2:0], ge};
    end
  end

  assign quot = dq;

endmodule

// ----- rtl/core/upa_sqrt.sv -----
// Digit-by-digit integer square root, two radicand bits per cycle (floor).
// Depends on upa_pkg.
module upa_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  upa_pkg::sq_t   radicand,
  output logic           done,
  output upa_pkg::root_t root
);

  localparam int RB = upa_pkg::ROOT_BITS;
  localparam int CW = $clog2(RB + 1);

  logic [CW-1:0]  count;
  logic           busy;
  upa_pkg::sq_t   rad;
  upa_pkg::root_t rt;
  logic [RB+1:0]  rem;
  logic [RB+3:0]  sh;
  logic [RB+3:0]  trial;
  logic [RB+3:0]  diff;
  logic           ge;

  assign sh    = {rem, rad[upa_pkg::SQ_BITS-1:upa_pkg::SQ_BITS-2]};
  assign trial = {2'b00, rt, 2'b01};
  assign ge    = sh >= trial;
  assign diff  = sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(RB);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rt  <= '0;
      rem <= '0;
    end else if (busy) begin
      rad <= rad << 2;
      rt  <= {rt[RB-2:0], ge};
      rem <= ge ? diff[RB+1:0] : sh[RB+1:0];
    end
  end

  assign root = rt;

endmodule

// ----- rtl/core/uncertainty_propagation_accumulator_unit.sv -----
// Top level: sequencer, accumulators and result register of the uncertainty
// propagation accumulator. Depends on upa_pkg, upa_if, upa_mul, upa_div, upa_sqrt.
//
//   channel  dir  word                                       taken when
//   cfg      in   data (mode: 0 sum, 1 product)              valid & ready
//   item     in   value, error, last                         valid & ready
//   result   out  result_value, result_error, status         valid & ready
//
// One item at a time. Sum mode: one serial square per item. Product mode: serial
// product, serial division, serial square. A last word adds the serial root, plus
// a serial product in product mode. Reset is synchronous and takes effect at once.
// A waiting result holds off only the next last word; other words go on.
module uncertainty_propagation_accumulator_unit (
  input logic            clk,
  input logic            rst,
  upa_cfg_if.sink        cfg,
  upa_in_if.sink         item,
  upa_out_if.source      result
);

  localparam int W = upa_pkg::WORD_BITS;
  localparam int F = upa_pkg::FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_VMUL,
    S_DIV,
    S_SQMUL,
    S_RSTART,
    S_ROOT,
    S_EMUL,
    S_OUT
  } state_t;

  typedef logic [upa_pkg::QUOT_BITS+upa_pkg::ROOT_BITS-1:0] quot_ext_t;

  state_t           state;
  upa_pkg::mode_t   mode;
  upa_pkg::word_t   rv;
  upa_pkg::sq_t     square_sum;
  logic             sat_seen;
  logic             zero_seen;
  upa_pkg::word_t   v;
  upa_pkg::mag_t    va;
  upa_pkg::mag_t    ea;
  logic             last;
  upa_pkg::err_t    err;
  logic             err_sat;

  logic             res_valid;
  upa_pkg::word_t   res_value;
  upa_pkg::err_t    res_error;
  upa_pkg::status_t res_status;

  logic             mul_start, mul_done;
  upa_pkg::mul_t    mul_a, mul_b;
  upa_pkg::prod_t   mul_p;
  logic             div_start, div_done;
  upa_pkg::quot_t   quot;
  logic             sqrt_start, sqrt_done;
  upa_pkg::root_t   root;

  logic             cfg_take, item_take;
  upa_pkg::mag_t    rv_mag;
  logic             quot_big;
  logic             prod_neg;
  logic signed [W:0] sum_ext;
  logic             sum_ovf;
  upa_pkg::word_t   sum_next;
  upa_pkg::wide_t   scaled;
  upa_pkg::mag_t    v_limit;
  logic             v_sat;
  upa_pkg::mag_t    v_mag_next;
  upa_pkg::wide_t   sq_add;
  logic             sq_ovf;
  logic             root_sat;
  logic             emul_sat;

  function automatic upa_pkg::mag_t mag(upa_pkg::word_t x);
    return x[W-1] ? upa_pkg::mag_t'(-x) : upa_pkg::mag_t'(x);
  endfunction

  upa_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  upa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (ea),
    .den   (va),
    .done  (div_done),
    .quot  (quot)
  );

  upa_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (square_sum),
    .done     (sqrt_done),
    .root     (root)
  );

  assign cfg.ready  = (state == S_IDLE);
  assign item.ready = (state == S_IDLE) && !cfg.valid;
  assign cfg_take   = cfg.valid && cfg.ready;
  assign item_take  = item.valid && item.ready;

  assign result.valid        = res_valid;
  assign result.result_value = res_value;
  assign result.result_error = res_error;
  assign result.status       = res_status;

  assign rv_mag   = mag(rv);
  assign quot_big = (quot_ext_t'(quot) >> upa_pkg::ROOT_BITS) != '0;
  assign prod_neg = rv[W-1] != v[W-1];

  // sum mode running value, saturating
  assign sum_ext  = {rv[W-1], rv} + {v[W-1], v};
  assign sum_ovf  = sum_ext[W] != sum_ext[W-1];
  assign sum_next = sum_ovf ? (sum_ext[W] ? upa_pkg::word_t'(upa_pkg::NEG_MAX)
                                          : upa_pkg::word_t'(upa_pkg::POS_MAX))
                            : sum_ext[W-1:0];

  // rounded Q-scaled product, half away from zero on the magnitude
  assign scaled     = (upa_pkg::wide_t'(mul_p) + upa_pkg::HALF_LSB) >> F;
  assign v_limit    = prod_neg ? upa_pkg::NEG_MAX : upa_pkg::POS_MAX;
  assign v_sat      = scaled > upa_pkg::wide_t'(v_limit);
  assign v_mag_next = v_sat ? v_limit : upa_pkg::mag_t'(scaled);
  assign emul_sat   = scaled > upa_pkg::wide_t'(upa_pkg::POS_MAX);

  assign sq_add = upa_pkg::wide_t'(mul_p) + upa_pkg::wide_t'(square_sum);
  assign sq_ovf = (sq_add >> upa_pkg::SQ_BITS) != '0;

  assign root_sat = upa_pkg::mul_t'(root) > upa_pkg::mul_t'(upa_pkg::POS_MAX);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      S_STEP: begin
        mul_start = 1'b1;
        if (mode == upa_pkg::MODE_SUM) begin
          mul_a = upa_pkg::mul_t'(ea);
          mul_b = upa_pkg::mul_t'(ea);
        end else begin
          mul_a = upa_pkg::mul_t'(rv_mag);
          mul_b = upa_pkg::mul_t'(va);
        end
      end
      S_DIV: begin
        mul_start = div_done && !quot_big;
        mul_a     = upa_pkg::mul_t'(upa_pkg::root_t'(quot));
        mul_b     = upa_pkg::mul_t'(upa_pkg::root_t'(quot));
      end
      S_ROOT: begin
        mul_start = sqrt_done && (mode == upa_pkg::MODE_PROD);
        mul_a     = upa_pkg::mul_t'(root);
        mul_b     = upa_pkg::mul_t'(rv_mag);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  assign div_start  = (state == S_VMUL) && mul_done && (va != '0);
  assign sqrt_start = (state == S_RSTART);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= upa_pkg::MODE_SUM;
      rv         <= '0;
      square_sum <= '0;
      sat_seen   <= 1'b0;
      zero_seen  <= 1'b0;
      err_sat    <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && result.ready && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_take) begin
            mode       <= upa_pkg::mode_t'(cfg.data);
            rv         <= cfg.data ? upa_pkg::FIX_ONE : '0;
            square_sum <= '0;
            sat_seen   <= 1'b0;
            zero_seen  <= 1'b0;
          end else if (item_take) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (mode == upa_pkg::MODE_SUM) begin
            rv <= sum_next;
            if (sum_ovf) begin
              sat_seen <= 1'b1;
            end
            state <= S_SQMUL;
          end else begin
            state <= S_VMUL;
          end
        end
        S_VMUL: begin
          if (mul_done) begin
            rv <= prod_neg ? upa_pkg::word_t'(-v_mag_next) : upa_pkg::word_t'(v_mag_next);
            if (v_sat) begin
              sat_seen <= 1'b1;
            end
            if (va == '0) begin
              zero_seen <= 1'b1;
              state     <= last ? S_RSTART : S_IDLE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (quot_big) begin
              square_sum <= '1;
              sat_seen   <= 1'b1;
              state      <= last ? S_RSTART : S_IDLE;
            end else begin
              state <= S_SQMUL;
            end
          end
        end
        S_SQMUL: begin
          if (mul_done) begin
            square_sum <= sq_ovf ? '1 : upa_pkg::sq_t'(sq_add);
            if (sq_ovf) begin
              sat_seen <= 1'b1;
            end
            state <= last ? S_RSTART : S_IDLE;
          end
        end
        S_RSTART: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sqrt_done) begin
            if (mode == upa_pkg::MODE_SUM) begin
              err     <= root_sat ? upa_pkg::err_t'(upa_pkg::POS_MAX)
                                  : upa_pkg::err_t'(root);
              err_sat <= root_sat;
              state   <= S_OUT;
            end else begin
              state <= S_EMUL;
            end
          end
        end
        S_EMUL: begin
          if (mul_done) begin
            err     <= emul_sat ? upa_pkg::err_t'(upa_pkg::POS_MAX)
                                : upa_pkg::err_t'(scaled);
            err_sat <= emul_sat;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || result.ready) begin
            res_valid  <= 1'b1;
            res_value  <= rv;
            res_error  <= err;
            res_status <= zero_seen ? upa_pkg::ST_ZERO
                        : (sat_seen || err_sat) ? upa_pkg::ST_SAT : upa_pkg::ST_OK;
            rv         <= (mode == upa_pkg::MODE_PROD) ? upa_pkg::FIX_ONE : '0;
            square_sum <= '0;
            sat_seen   <= 1'b0;
            zero_seen  <= 1'b0;
            err_sat    <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      v    <= item.value;
      va   <= mag(item.value);
      ea   <= mag(item.error);
      last <= item.last;
    end
  end

endmodule

// ----- dv/tb_uncertainty_propagation_accumulator_unit.sv -----
// Self-checking testbench for uncertainty_propagation_accumulator_unit: directed and random
// (value, error, last) words in sum and product mode, checked against an in-bench predictor.
// Depends on upa_pkg and the channel interfaces in upa_if.
module tb_uncertainty_propagation_accumulator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import upa_pkg::*;

  typedef struct packed {
    word_t value;
    word_t error;
    logic  last;
  } pair_t;

  typedef struct packed {
    word_t   value;
    err_t    error;
    status_t status;
  } outcome_t;

  localparam int          RUN_LEN       = 238;
  localparam int          SETTLE_CYCLES = 400;
  localparam int          IDLE_LIMIT    = 4000;
  localparam logic [63:0] POS_LIM       = 64'(POS_MAX);
  localparam logic [63:0] NEG_LIM       = 64'(NEG_MAX);
  localparam longint      VAL_HI        = longint'(POS_LIM);
  localparam longint      VAL_LO        = -longint'(NEG_LIM);

  logic clk = 1'b0;
  logic rst = 1'b1;

  upa_cfg_if cfg_ch();
  upa_in_if  item_ch();
  upa_out_if result_ch();

  uncertainty_propagation_accumulator_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pair_t       pair_queue[$];
  outcome_t    owed_results[$];
  pair_t       on_wire;
  int unsigned send_gap_pct;
  int unsigned recv_gap_pct;
  int          mismatches = 0;
  int          idle_cycles = 0;

  // predictor state
  mode_t       acc_mode = MODE_SUM;
  longint      acc_value = 0;
  logic [63:0] acc_sq = '0;
  status_t     acc_status = ST_OK;

  function automatic void restart_acc();
    acc_value  = (acc_mode == MODE_PROD) ? longint'(FIX_ONE) : 0;
    acc_sq     = '0;
    acc_status = ST_OK;
  endfunction

  function automatic void raise_flag(status_t code);
    if (code == ST_ZERO) acc_status = ST_ZERO;
    else if (acc_status == ST_OK) acc_status = code;
  endfunction

  function automatic logic [63:0] magnitude(longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  // round half away from zero on magnitudes, clamp to limit
  function automatic logic [63:0] rounded_product(logic [63:0] a, logic [63:0] b,
                                                  logic [63:0] limit, output bit ovf);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    ovf = (p > 128'(limit));
    return ovf ? limit : p[63:0];
  endfunction

  function automatic void add_square(logic [63:0] term, bit big);
    logic [64:0] s;
    s = {1'b0, acc_sq} + {1'b0, term};
    if (big || s[64]) begin
      acc_sq = '1;
      raise_flag(ST_SAT);
    end else begin
      acc_sq = s[63:0];
    end
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void propagate_pair(pair_t p);
    longint      v;
    longint      s;
    logic [63:0] va;
    logic [63:0] ea;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] err;
    bit          neg;
    bit          ovf;
    v  = longint'($signed(p.value));
    va = magnitude(v);
    ea = magnitude(longint'($signed(p.error)));
    if (acc_mode == MODE_SUM) begin
      s = acc_value + v;
      ovf = 1'b0;
      if (s > VAL_HI) begin
        s = VAL_HI;
        ovf = 1'b1;
      end
      if (s < VAL_LO) begin
        s = VAL_LO;
        ovf = 1'b1;
      end
      acc_value = s;
      if (ovf) raise_flag(ST_SAT);
      add_square(ea * ea, 1'b0);
    end else begin
      neg = (acc_value < 0) != (v < 0);
      m = rounded_product(magnitude(acc_value), va, neg ? NEG_LIM : POS_LIM, ovf);
      acc_value = neg ? -longint'(m) : longint'(m);
      if (ovf) raise_flag(ST_SAT);
      if (va == 0) begin
        raise_flag(ST_ZERO);
      end else begin
        q = (ea << FRAC_BITS) / va;
        if (q > 64'hFFFF_FFFF) add_square('0, 1'b1);
        else add_square(q * q, 1'b0);
      end
    end
    if (!p.last) return;
    if (acc_mode == MODE_SUM) begin
      err = floor_sqrt(acc_sq);
      ovf = (err > POS_LIM);
      if (ovf) err = POS_LIM;
    end else begin
      err = rounded_product(floor_sqrt(acc_sq), magnitude(acc_value), POS_LIM, ovf);
    end
    if (ovf) raise_flag(ST_SAT);
    owed_results.push_back('{word_t'(acc_value), err_t'(err), acc_status});
    restart_acc();
  endfunction

  // stimulus helpers
  function automatic void push_pair(word_t v, word_t e, logic l);
    pair_queue.push_back('{v, e, l});
  endfunction

  function automatic word_t signed_mag(int unsigned lo, int unsigned hi);
    word_t w;
    w = word_t'($urandom_range(hi, lo));
    return $urandom_range(1) ? -w : w;
  endfunction

  function automatic word_t edge_word();
    case ($urandom_range(6))
      0:       return '0;
      1:       return word_t'(1);
      2:       return '1;
      3:       return word_t'(POS_MAX);
      4:       return word_t'(NEG_MAX);
      5:       return FIX_ONE;
      default: return -FIX_ONE;
    endcase
  endfunction

  function automatic word_t pick_value(mode_t m);
    int unsigned r;
    r = $urandom_range(19);
    if (m == MODE_SUM) begin
      if (r < 12) return signed_mag(0, 32'h00FF_FFFF);
      if (r < 17) return word_t'($urandom);
      return edge_word();
    end
    if (r < 12) return signed_mag(32'h0000_C000, 32'h0001_4000);
    if (r == 12) return '0;
    if (r < 15) return signed_mag(1, 32'h0000_0400);
    if (r < 18) return word_t'($urandom);
    return edge_word();
  endfunction

  function automatic word_t pick_error();
    int unsigned r;
    r = $urandom_range(19);
    if (r < 14) return signed_mag(0, 32'h0000_FFFF);
    if (r < 18) return word_t'($urandom);
    return edge_word();
  endfunction

  task automatic queue_run(mode_t m, int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
      for (int i = 0; i < len; i++) push_pair(pick_value(m), pick_error(), i == len - 1);
      n += len;
    end
  endtask

  task automatic settle();
    while (pair_queue.size() != 0 || item_ch.valid || owed_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(mode_t m);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    acc_mode = m;
    restart_acc();
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) propagate_pair(on_wire);
      if (!item_ch.valid || item_ch.ready) begin
        if (pair_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          on_wire = pair_queue.pop_front();
          item_ch.valid <= 1'b1;
          item_ch.value <= on_wire.value;
          item_ch.error <= on_wire.error;
          item_ch.last  <= on_wire.last;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (owed_results.size() == 0) begin
          note_mismatch("unexpected result word", '0, 64'(result_ch.result_value));
        end else begin
          want = owed_results.pop_front();
          if (result_ch.result_value !== want.value)
            note_mismatch("result_value", 64'(want.value), 64'(result_ch.result_value));
          if (result_ch.result_error !== want.error)
            note_mismatch("result_error", 64'(want.error), 64'(result_ch.result_error));
          if (result_ch.status !== want.status)
            note_mismatch("status", 64'(want.status), 64'(result_ch.status));
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    item_ch.valid   = 1'b0;
    item_ch.value   = '0;
    item_ch.error   = '0;
    item_ch.last    = 1'b0;
    result_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = 1'b0;
    send_gap_pct    = 7;
    recv_gap_pct    = 55;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // sum mode: extremes, value clamp, square sum overflow, error clamp
    push_pair(word_t'(POS_MAX), '0, 1'b1);
    push_pair(word_t'(NEG_MAX), word_t'(NEG_MAX), 1'b1);
    push_pair(word_t'(POS_MAX), 32'h0000_0001, 1'b0);
    push_pair(word_t'(POS_MAX), '1, 1'b1);
    for (int i = 0; i < 5; i++)
      push_pair(i[0] ? -FIX_ONE : FIX_ONE, word_t'(NEG_MAX), i == 4);
    push_pair(32'h0001_8000, 32'h0000_8000, 1'b1);
    // open calculation, dropped by the mode write
    push_pair(32'h0001_2345, 32'h0000_0100, 1'b0);
    settle();
    write_mode(MODE_PROD);

    // product mode: sign, zero value, both flags, relative overflow, rounding, clamps
    push_pair(32'h0002_0000, 32'h0000_1000, 1'b0);
    push_pair(32'hFFFF_8000, 32'h0000_0800, 1'b1);
    push_pair('0, 32'h0000_0100, 1'b1);
    push_pair(word_t'(POS_MAX), '0, 1'b0);
    push_pair(32'h0002_0000, '0, 1'b0);
    push_pair('0, '0, 1'b1);
    push_pair(32'h0000_0001, word_t'(POS_MAX), 1'b1);
    push_pair(32'h0001_8000, '0, 1'b0);
    push_pair(32'h0000_0001, '0, 1'b1);
    push_pair(word_t'(NEG_MAX), word_t'(POS_MAX), 1'b1);
    push_pair(word_t'(NEG_MAX), '0, 1'b0);
    push_pair(word_t'(NEG_MAX), '0, 1'b1);
    push_pair(32'h7FFF_0000, word_t'(POS_MAX), 1'b0);
    push_pair(FIX_ONE, 32'h0002_0000, 1'b1);

    for (int p = 0; p < 3; p++) begin
      if (p != 0) begin
        settle();
        send_gap_pct = (p == 1) ? 55 : 0;
        recv_gap_pct = (p == 1) ? 7 : 0;
        write_mode(MODE_PROD);
      end
      queue_run(MODE_PROD, RUN_LEN);
      settle();
      write_mode(MODE_SUM);
      queue_run(MODE_SUM, RUN_LEN);
    end
    settle();

    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
